// ===== src/jsu_pkg.sv =====
// jsu_pkg: shared types and constants for the json string unescaper
// no dependencies; referenced by the channel interfaces and imported by the top level
`default_nettype none

package jsu_pkg;

  // payload widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned KindW    = 2;
  localparam int unsigned ErrW     = 4;
  localparam int unsigned MaxRes   = 4;

  typedef logic [ByteW-1:0] byte_t;

  // result kind codes
  typedef enum logic [KindW-1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  // error codes
  typedef enum logic [ErrW-1:0] {
    ERR_NONE      = 4'd0,
    ERR_CTRL      = 4'd1,
    ERR_BAD_ESC   = 4'd2,
    ERR_BAD_HEX   = 4'd3,
    ERR_TRUNC_U   = 4'd4,
    ERR_UNPAIRED  = 4'd5,
    ERR_BAD_LOW   = 4'd6,
    ERR_STRAY_LOW = 4'd7,
    ERR_UNTERM_ES = 4'd8,
    ERR_UNTERM_ST = 4'd9
  } err_e;

  // one queued result
  typedef struct packed {
    byte_t data;
    kind_e kind;
    err_e  err;
  } res_t;

  // character codes
  localparam byte_t ChQuote  = 8'h22;
  localparam byte_t ChBslash = 8'h5C;
  localparam byte_t ChSlash  = 8'h2F;
  localparam byte_t ChB      = 8'h62;
  localparam byte_t ChF      = 8'h66;
  localparam byte_t ChN      = 8'h6E;
  localparam byte_t ChR      = 8'h72;
  localparam byte_t ChT      = 8'h74;
  localparam byte_t ChU      = 8'h75;
  localparam byte_t ChSpace  = 8'h20;

  // surrogate bounds
  localparam logic [15:0] HighLo = 16'hD800;
  localparam logic [15:0] HighHi = 16'hDBFF;
  localparam logic [15:0] LowLo  = 16'hDC00;
  localparam logic [15:0] LowHi  = 16'hDFFF;

endpackage

`default_nettype wire

// ===== src/jsu_in_if.sv =====
// jsu_in_if: valid/ready channel carrying one source byte per beat
// depends on jsu_pkg
`default_nettype none

interface jsu_in_if;
  logic            valid;
  logic            ready;
  jsu_pkg::byte_t  in_byte;
  logic            end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

`default_nettype wire

// ===== src/jsu_out_if.sv =====
// jsu_out_if: valid/ready channel carrying one decoded result per beat
// depends on jsu_pkg
`default_nettype none

interface jsu_out_if;
  logic                        valid;
  logic                        ready;
  jsu_pkg::byte_t              out_byte;
  logic [jsu_pkg::KindW-1:0]   kind;
  logic [jsu_pkg::ErrW-1:0]    err_code;
  logic                        last;

  modport source (output valid, output out_byte, output kind, output err_code,
                  output last, input ready);
  modport sink   (input valid, input out_byte, input kind, input err_code,
                  input last, output ready);
endinterface

`default_nettype wire

// ===== src/json_string_unescape_utf8.sv =====
// json_string_unescape_utf8: json string body unescaper with utf-8 output
// depends on jsu_pkg, jsu_in_if, jsu_out_if
// latency: first result of a beat is presented the cycle after it is accepted
// throughput: one input beat per cycle while each beat yields at most one result and
//   the output is ready; a beat that yields several results (utf-8 of 2 to 4 bytes) holds
//   the input until its final result leaves the 4-entry result queue, which drains one result per output beat
// reset: decoder back in the string body phase, result queue empty
`default_nettype none

module json_string_unescape_utf8 (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);
  import jsu_pkg::*;

  // one-hot decoder phase
  typedef enum logic [5:0] {
    PH_BODY    = 6'b000001,
    PH_ESC     = 6'b000010,
    PH_HEX1    = 6'b000100,
    PH_PAIR_BS = 6'b001000,
    PH_PAIR_U  = 6'b010000,
    PH_HEX2    = 6'b100000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] acc_q, acc_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [9:0]  high_q, high_d;

  res_t        res_q [MaxRes];
  res_t        res_d [MaxRes];
  res_t        dec   [MaxRes];
  logic [2:0]  rem_q, rem_d;
  logic [2:0]  n_dec;

  logic        in_fire, out_fire;

  logic        dig_ok;
  logic [3:0]  dig_val;
  logic [15:0] acc_new;
  logic [20:0] cp_pair;

  // hex digit decode
  always_comb begin
    dig_ok  = 1'b1;
    dig_val = 4'd0;
    if (in_i.in_byte >= 8'h30 && in_i.in_byte <= 8'h39) begin
      dig_val = in_i.in_byte[3:0];
    end else if ((in_i.in_byte >= 8'h61 && in_i.in_byte <= 8'h66) ||
                 (in_i.in_byte >= 8'h41 && in_i.in_byte <= 8'h46)) begin
      dig_val = in_i.in_byte[3:0] + 4'd9;
    end else begin
      dig_ok = 1'b0;
    end
  end

  assign acc_new = {acc_q[11:0], dig_val};
  assign cp_pair = 21'h10000 + {1'b0, high_q, acc_new[9:0]};

  function automatic res_t mk_data(input byte_t b);
    res_t r;
    r.data = b;
    r.kind = KIND_DATA;
    r.err  = ERR_NONE;
    return r;
  endfunction

  function automatic res_t mk_flag(input kind_e k, input err_e e);
    res_t r;
    r.data = '0;
    r.kind = k;
    r.err  = e;
    return r;
  endfunction

  // decoder: next state and the results of the incoming beat
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    high_d  = high_q;
    n_dec   = 3'd0;
    for (int i = 0; i < MaxRes; i++) begin
      dec[i] = mk_flag(KIND_ERR, ERR_NONE);
    end

    if (in_i.end_of_input) begin
      unique case (phase_q)
        PH_ESC:               dec[0] = mk_flag(KIND_ERR, ERR_UNTERM_ES);
        PH_HEX1, PH_HEX2:     dec[0] = mk_flag(KIND_ERR, ERR_TRUNC_U);
        PH_PAIR_BS, PH_PAIR_U: dec[0] = mk_flag(KIND_ERR, ERR_UNPAIRED);
        default:              dec[0] = mk_flag(KIND_ERR, ERR_UNTERM_ST);
      endcase
      n_dec = 3'd1;
    end else begin
      unique case (phase_q)
        PH_ESC: begin
          n_dec   = 3'd1;
          phase_d = PH_BODY;
          unique case (in_i.in_byte)
            ChQuote, ChBslash, ChSlash: dec[0] = mk_data(in_i.in_byte);
            ChB: dec[0] = mk_data(8'h08);
            ChF: dec[0] = mk_data(8'h0C);
            ChN: dec[0] = mk_data(8'h0A);
            ChR: dec[0] = mk_data(8'h0D);
            ChT: dec[0] = mk_data(8'h09);
            ChU: begin
              n_dec   = 3'd0;
              phase_d = PH_HEX1;
              acc_d   = '0;
              cnt_d   = '0;
            end
            default: dec[0] = mk_flag(KIND_ERR, ERR_BAD_ESC);
          endcase
        end

        PH_HEX1: begin
          if (!dig_ok) begin
            n_dec  = 3'd1;
            dec[0] = mk_flag(KIND_ERR, ERR_BAD_HEX);
          end else if (cnt_q != 2'd3) begin
            acc_d = acc_new;
            cnt_d = cnt_q + 2'd1;
          end else if (acc_new >= HighLo && acc_new <= HighHi) begin
            high_d  = acc_new[9:0];
            acc_d   = '0;
            cnt_d   = '0;
            phase_d = PH_PAIR_BS;
          end else if (acc_new >= LowLo && acc_new <= LowHi) begin
            n_dec  = 3'd1;
            dec[0] = mk_flag(KIND_ERR, ERR_STRAY_LOW);
          end else if (acc_new < 16'h0080) begin
            n_dec  = 3'd1;
            dec[0] = mk_data(acc_new[7:0]);
          end else if (acc_new < 16'h0800) begin
            n_dec  = 3'd2;
            dec[0] = mk_data({3'b110, acc_new[10:6]});
            dec[1] = mk_data({2'b10, acc_new[5:0]});
          end else begin
            n_dec  = 3'd3;
            dec[0] = mk_data({4'b1110, acc_new[15:12]});
            dec[1] = mk_data({2'b10, acc_new[11:6]});
            dec[2] = mk_data({2'b10, acc_new[5:0]});
          end
        end

        PH_PAIR_BS: begin
          if (in_i.in_byte != ChBslash) begin
            n_dec  = 3'd1;
            dec[0] = mk_flag(KIND_ERR, ERR_UNPAIRED);
          end else begin
            phase_d = PH_PAIR_U;
          end
        end

        PH_PAIR_U: begin
          if (in_i.in_byte != ChU) begin
            n_dec  = 3'd1;
            dec[0] = mk_flag(KIND_ERR, ERR_UNPAIRED);
          end else begin
            phase_d = PH_HEX2;
            acc_d   = '0;
            cnt_d   = '0;
          end
        end

        PH_HEX2: begin
          if (!dig_ok) begin
            n_dec  = 3'd1;
            dec[0] = mk_flag(KIND_ERR, ERR_BAD_HEX);
          end else if (cnt_q != 2'd3) begin
            acc_d = acc_new;
            cnt_d = cnt_q + 2'd1;
          end else if (acc_new < LowLo || acc_new > LowHi) begin
            n_dec  = 3'd1;
            dec[0] = mk_flag(KIND_ERR, ERR_BAD_LOW);
          end else begin
            n_dec  = 3'd4;
            dec[0] = mk_data({5'b11110, cp_pair[20:18]});
            dec[1] = mk_data({2'b10, cp_pair[17:12]});
            dec[2] = mk_data({2'b10, cp_pair[11:6]});
            dec[3] = mk_data({2'b10, cp_pair[5:0]});
          end
        end

        default: begin
          phase_d = PH_BODY;
          if (in_i.in_byte == ChQuote) begin
            n_dec  = 3'd1;
            dec[0] = mk_flag(KIND_DONE, ERR_NONE);
          end else if (in_i.in_byte == ChBslash) begin
            phase_d = PH_ESC;
          end else if (in_i.in_byte < ChSpace) begin
            n_dec  = 3'd1;
            dec[0] = mk_flag(KIND_ERR, ERR_CTRL);
          end else begin
            n_dec  = 3'd1;
            dec[0] = mk_data(in_i.in_byte);
          end
        end
      endcase
    end

    // any error or done result clears the decoder
    if (n_dec != 3'd0 && dec[0].kind != KIND_DATA) begin
      phase_d = PH_BODY;
      acc_d   = '0;
      cnt_d   = '0;
      high_d  = '0;
    end
    // a completed code point also clears the decoder
    if (n_dec != 3'd0 && dec[0].kind == KIND_DATA &&
        (phase_q == PH_HEX1 || phase_q == PH_HEX2)) begin
      phase_d = PH_BODY;
      acc_d   = '0;
      cnt_d   = '0;
      high_d  = '0;
    end
  end

  // handshake: accept when the queue is empty or its final entry leaves now
  assign out_fire   = out_o.valid && out_o.ready;
  assign in_i.ready = (rem_q == 3'd0) || (rem_q == 3'd1 && out_o.ready);
  assign in_fire    = in_i.valid && in_i.ready;

  // result queue: load on accept, shift down on each output beat
  always_comb begin
    rem_d = rem_q;
    for (int i = 0; i < MaxRes; i++) begin
      res_d[i] = res_q[i];
    end
    if (in_fire) begin
      rem_d = n_dec;
      for (int i = 0; i < MaxRes; i++) begin
        res_d[i] = dec[i];
      end
    end else if (out_fire) begin
      rem_d = rem_q - 3'd1;
      for (int i = 0; i < MaxRes - 1; i++) begin
        res_d[i] = res_q[i+1];
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_BODY;
      acc_q   <= '0;
      cnt_q   <= '0;
      high_q  <= '0;
      rem_q   <= '0;
    end else begin
      rem_q <= rem_d;
      if (in_fire) begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        cnt_q   <= cnt_d;
        high_q  <= high_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxRes; i++) begin
      res_q[i] <= res_d[i];
    end
  end

  // output beat
  assign out_o.valid    = (rem_q != 3'd0);
  assign out_o.out_byte = res_q[0].data;
  assign out_o.kind     = res_q[0].kind;
  assign out_o.err_code = res_q[0].err;
  assign out_o.last     = (rem_q == 3'd1);

endmodule

`default_nettype wire
